@@ src/sphke_pkg.sv @@
`timescale 1ns / 1ps

package sphke_pkg;

  // Output fraction bits
  localparam int OUT_FRAC_BITS_DEF = 16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SELECT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_LENGTH = 2'd1;

  // Kernel selector codes
  localparam logic [1:0] KSEL_GAUSS  = 2'd0;
  localparam logic [1:0] KSEL_CUBIC  = 2'd1;
  localparam logic [1:0] KSEL_WEND   = 2'd2;
  localparam logic [1:0] KSEL_UNUSED = 2'd3;

  // Normalization constants C in Q.32
  localparam logic [31:0] CQ_GAUSS = 32'd1367130551;
  localparam logic [31:0] CQ_CUBIC = 32'd1953043645;
  localparam logic [31:0] CQ_WEND  = 32'd2392478465;

  // Quotient bits produced by each divider
  localparam int QUO_W = 32;

  // Sideband carried alongside the dividers
  typedef struct packed {
    logic valid;
    logic sx;
    logic sy;
  } side_t;

  // exp(-q^2) table, split into even and odd entries so that two
  // neighbors come out of two single-port reads
  localparam int EXP_HALF = 1024;
  localparam logic [63:0] LN2_Q31 = 64'd1488522236;

  typedef logic [31:0] exp_even_t [0:EXP_HALF];
  typedef logic [31:0] exp_odd_t  [0:EXP_HALF-1];

  // Long division for the table build; evaluated at elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    logic [63:0] qt;
    r  = 64'd0;
    qt = 64'd0;
    for (int bi = 63; bi >= 0; bi--) begin
      r = {r[62:0], a[bi]};
      if (r >= b) begin
        r      = r - b;
        qt[bi] = 1'b1;
      end
    end
    return qt;
  endfunction

  function automatic logic [31:0] exp_entry(input int unsigned idx);
    logic [63:0] y;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] kk;
    logic [63:0] res;
    y = (64'(idx) * 64'(idx)) << 15;
    n = udiv64(y, LN2_Q31);
    f = y - n * LN2_Q31;
    pos = 64'd1 << 31;
    neg = 64'd0;
    term = 64'd1 << 31;
    // Taylor series of exp(-frac), terms up to the twelfth power
    for (int k = 1; k <= 12; k++) begin
      kk = 64'(k);
      term = udiv64(term * f + (kk << 30), kk << 31);
      if (kk[0]) neg = neg + term;
      else pos = pos + term;
    end
    s = pos - neg;
    if (n == 64'd0) res = s;
    else if (n >= 64'd40) res = 64'd0;
    else res = (s >> n) + ((s >> (n - 64'd1)) & 64'd1);
    return res[31:0];
  endfunction

  function automatic exp_even_t make_exp_even();
    exp_even_t t;
    for (int j = 0; j <= EXP_HALF; j++) t[j] = exp_entry(2 * j);
    return t;
  endfunction

  function automatic exp_odd_t make_exp_odd();
    exp_odd_t t;
    for (int j = 0; j < EXP_HALF; j++) t[j] = exp_entry(2 * j + 1);
    return t;
  endfunction

  localparam exp_even_t EXP_EVEN = make_exp_even();
  localparam exp_odd_t  EXP_ODD  = make_exp_odd();

endpackage

@@ src/sphke_div.sv @@
`timescale 1ns / 1ps

// Pipelined restoring divider: one quotient bit per stage. quo is
// floor(num / den) unless ovf flags a quotient >= 2^QUO_W. The user
// must hold the divisor steady while items are in flight (unchecked).
module sphke_div #(
  parameter int NUM_W = 65,
  parameter int DEN_W = 59
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [NUM_W-1:0]            num,
  input  logic [DEN_W-1:0]            den,
  output logic [sphke_pkg::QUO_W-1:0] quo,
  output logic                        ovf
);

  localparam int QW = sphke_pkg::QUO_W;
  localparam int HI_W = NUM_W - QW;
  localparam int CW = ((HI_W > DEN_W) ? HI_W : DEN_W) + 1;

  logic [DEN_W-1:0] rem     [0:QW];
  logic [QW-1:0]    low     [0:QW];
  logic [QW-1:0]    quo_acc [0:QW];
  logic             ovf_acc [0:QW];

  logic [CW-1:0] hi_x;
  logic [CW-1:0] den_x;

  assign hi_x  = CW'(num >> QW);
  assign den_x = CW'(den);

  // Split off the high part and check the quotient range
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]     <= DEN_W'(num >> QW);
      low[0]     <= num[QW-1:0];
      quo_acc[0] <= '0;
      ovf_acc[0] <= (hi_x >= den_x);
    end
  end

  // One compare and subtract per stage
  for (genvar j = 1; j <= QW; j++) begin : g_stage
    logic [DEN_W:0] trial;
    logic           take;

    assign trial = {rem[j-1], low[j-1][QW-1]};
    assign take  = (trial >= {1'b0, den});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j]     <= take ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        low[j]     <= {low[j-1][QW-2:0], 1'b0};
        quo_acc[j] <= {quo_acc[j-1][QW-2:0], take};
        ovf_acc[j] <= ovf_acc[j-1];
      end
    end
  end

  assign quo = quo_acc[QW];
  assign ovf = ovf_acc[QW];

endmodule

@@ src/sph_kernel_evaluator_core.sv @@
`timescale 1ns / 1ps

// SPH smoothing kernel evaluator (2-D Gaussian, cubic spline, Wendland C2).
// Input channel: norm_distance (q, Q4.16) and dir_x/dir_y (Q1.15), taken
// on in_valid high with in_stall low. Output channel: weight, grad_x and
// grad_y in signed Q(32-OUT_FRAC_BITS).OUT_FRAC_BITS, saturating, taken on
// out_valid high with out_stall low.
// Configuration: cfg_index 0 selects the kernel, 1 sets the smoothing
// length h (Q6.10); cfg_ready is always high. Write only while idle.
// Throughput: one item per cycle while the output is not stalled. The
// pipeline holds seven shape/scale stages ahead of the 32-bit, one bit
// per stage quotient pipelines that divide by h^2 and h^3.
// A stalled output freezes the whole pipeline; in_stall is then high and
// nothing is lost or repeated. When the output register is empty the pipe
// flows regardless of out_stall.
// Reset clears all valid bits and loads kernel_select = cubic spline and
// h = 1.0; the exp table is a constant ROM, so no fill pass is needed.
module sph_kernel_evaluator_core #(
  parameter int OUT_FRAC_BITS = sphke_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [19:0]                     norm_distance,
  input  logic signed [15:0]              dir_x,
  input  logic signed [15:0]              dir_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [31:0]              weight,
  output logic signed [31:0]              grad_x,
  output logic signed [31:0]              grad_y,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sphke_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data
);

  localparam int QW = sphke_pkg::QUO_W;
  localparam int W_SHIFT = 43 - OUT_FRAC_BITS;
  localparam int G_SHIFT = 32 - OUT_FRAC_BITS;
  localparam int DW_W = 32 + W_SHIFT;
  localparam int DW_G = 48 + G_SHIFT;
  localparam int NW_W = 65;
  localparam int NW_G = 68;
  localparam int DIV_LAT = QW + 1;

  // ---------------- configuration ----------------
  logic [1:0]  kernel_select;
  logic [15:0] smoothing_length;
  logic [15:0] h_eff;
  logic [31:0] h_sq;
  logic [47:0] h_cube;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_select    <= sphke_pkg::KSEL_CUBIC;
      smoothing_length <= 16'd1024;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sphke_pkg::REG_KERNEL_SELECT:    kernel_select <= cfg_data[1:0];
        sphke_pkg::REG_SMOOTHING_LENGTH: smoothing_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Treat a zero length as one LSB; form h^2 and h^3
  assign h_eff = (smoothing_length == 16'd0) ? 16'd1 : smoothing_length;

  always_ff @(posedge clk) begin
    h_sq   <= 32'(h_eff) * 32'(h_eff);
    h_cube <= 48'(h_sq) * 48'(h_eff);
  end

  // ---------------- flow control ----------------
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic v1, v2, v3, v4, v5, v6, v7;

  // ---------------- input decode ----------------
  logic        in_support;
  logic        in_zero;
  logic        in_piece1;
  logic [17:0] in_x;
  logic [11:0] in_i1;

  always_comb begin
    if (kernel_select == sphke_pkg::KSEL_GAUSS) in_support = !norm_distance[19];
    else in_support = (norm_distance <= 20'd131072);
    in_zero   = (kernel_select == sphke_pkg::KSEL_UNUSED) || !in_support;
    in_piece1 = (norm_distance <= 20'd65536);
    if (kernel_select == sphke_pkg::KSEL_CUBIC && in_piece1) in_x = norm_distance[17:0];
    else in_x = 18'(18'h20000 - norm_distance[17:0]);
    in_i1 = {1'b0, norm_distance[18:8]} + 12'd1;
  end

  // Stage 1: register the item
  logic [19:0] p1_q;
  logic [15:0] p1_dx, p1_dy;
  logic [1:0]  p1_sel;
  logic        p1_zero, p1_piece1, p1_i0;
  logic [17:0] p1_x;
  logic [10:0] p1_ev;
  logic [9:0]  p1_od;

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_q      <= norm_distance;
      p1_dx     <= dir_x;
      p1_dy     <= dir_y;
      p1_sel    <= kernel_select;
      p1_zero   <= in_zero;
      p1_piece1 <= in_piece1;
      p1_x      <= in_x;
      p1_ev     <= in_i1[11:1];
      p1_od     <= norm_distance[18:9];
      p1_i0     <= norm_distance[8];
    end
  end

  // Stage 2: square and read the exp table
  logic [19:0] p2_q;
  logic [15:0] p2_dx, p2_dy;
  logic [1:0]  p2_sel;
  logic        p2_zero, p2_piece1, p2_i0;
  logic [17:0] p2_x;
  logic [35:0] p2_x2;
  logic [31:0] p2_e_even, p2_e_odd;

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_q      <= p1_q;
      p2_dx     <= p1_dx;
      p2_dy     <= p1_dy;
      p2_sel    <= p1_sel;
      p2_zero   <= p1_zero;
      p2_piece1 <= p1_piece1;
      p2_i0     <= p1_i0;
      p2_x      <= p1_x;
      p2_x2     <= 36'(p1_x) * 36'(p1_x);
      p2_e_even <= sphke_pkg::EXP_EVEN[p1_ev];
      p2_e_odd  <= sphke_pkg::EXP_ODD[p1_od];
    end
  end

  // Stage 3: cube, Wendland products, table interpolation products
  logic [31:0] e_lo, e_hi;
  logic [32:0] wend_a;
  logic [7:0]  frac_r;

  assign e_lo   = p2_i0 ? p2_e_odd : p2_e_even;
  assign e_hi   = p2_i0 ? p2_e_even : p2_e_odd;
  assign wend_a = 33'((p2_x2 >> 3) + 36'(p2_x2[2]));
  assign frac_r = p2_q[7:0];

  logic [19:0] p3_q;
  logic [15:0] p3_dx, p3_dy;
  logic [1:0]  p3_sel;
  logic        p3_zero, p3_piece1;
  logic [17:0] p3_x;
  logic [35:0] p3_x2;
  logic [53:0] p3_x3;
  logic [65:0] p3_aa;
  logic [50:0] p3_av;
  logic [40:0] p3_pa, p3_pb;

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_q      <= p2_q;
      p3_dx     <= p2_dx;
      p3_dy     <= p2_dy;
      p3_sel    <= p2_sel;
      p3_zero   <= p2_zero;
      p3_piece1 <= p2_piece1;
      p3_x      <= p2_x;
      p3_x2     <= p2_x2;
      p3_x3     <= 54'(p2_x2) * 54'(p2_x);
      p3_aa     <= 66'(wend_a) * 66'(wend_a);
      p3_av     <= 51'(wend_a) * 51'(p2_x);
      p3_pa     <= 41'(e_lo) * 41'(9'd256 - {1'b0, frac_r});
      p3_pb     <= 41'(e_hi) * 41'(frac_r);
    end
  end

  // Stage 4: cubic pieces, Wendland scaling products, Gaussian slope product
  logic [53:0] c1_f_sum, c1_g_sum, c2_g_sum;
  logic [32:0] cub_f;
  logic [34:0] cub_g;
  logic [33:0] wend_a4;
  logic [34:0] wend_a3;
  logic [18:0] wend_lin;
  logic [41:0] gau_sum;
  logic [32:0] gau_e;

  always_comb begin
    c1_f_sum = (54'd1 << 50) + 54'(p3_x3) * 54'd3 - ((54'(p3_x2) * 54'd3) << 17);
    c1_g_sum = ((54'(p3_x) * 54'd3) << 34) - ((54'(p3_x2) * 54'd9) << 16);
    c2_g_sum = 54'(p3_x2) * 54'd3;
    if (p3_piece1) begin
      cub_f = 33'((c1_f_sum >> 18) + 54'(c1_f_sum[17]));
      cub_g = 35'((c1_g_sum >> 18) + 54'(c1_g_sum[17]));
    end else begin
      cub_f = 33'((p3_x3 >> 18) + 54'(p3_x3[17]));
      cub_g = 35'((c2_g_sum >> 2) + 54'(c2_g_sum[1]));
    end
    wend_a4  = 34'((p3_aa >> 30) + 66'(p3_aa[29]));
    wend_a3  = 35'((p3_av >> 16) + 51'(p3_av[15]));
    wend_lin = {p3_q[17:0], 1'b0} + 19'd65536;
    gau_sum  = 42'(p3_pa) + 42'(p3_pb);
    gau_e    = 33'((gau_sum >> 8) + 42'(gau_sum[7]));
  end

  logic [15:0] p4_dx, p4_dy;
  logic [1:0]  p4_sel;
  logic        p4_zero;
  logic [32:0] p4_cf;
  logic [34:0] p4_cg;
  logic [52:0] p4_fp, p4_gp;
  logic [32:0] p4_e;
  logic [51:0] p4_gg;

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_dx   <= p3_dx;
      p4_dy   <= p3_dy;
      p4_sel  <= p3_sel;
      p4_zero <= p3_zero;
      p4_cf   <= cub_f;
      p4_cg   <= cub_g;
      p4_fp   <= 53'(wend_a4) * 53'(wend_lin);
      p4_gp   <= 53'(wend_a3) * 53'(p3_q[17:0]);
      p4_e    <= gau_e;
      p4_gg   <= 52'(gau_e) * 52'(p3_q[18:0]);
    end
  end

  // Stage 5: pick shape and slope for the selected kernel
  logic [55:0] wend_g5;
  logic [32:0] sel_f;
  logic [34:0] sel_g;
  logic [31:0] sel_cq;

  always_comb begin
    wend_g5 = 56'(p4_gp) * 56'd5;
    sel_f   = '0;
    sel_g   = '0;
    sel_cq  = sphke_pkg::CQ_CUBIC;
    case (p4_sel)
      sphke_pkg::KSEL_GAUSS: begin
        sel_f  = {p4_e[31:0], 1'b0};
        sel_g  = 35'((p4_gg >> 14) + 52'(p4_gg[13]));
        sel_cq = sphke_pkg::CQ_GAUSS;
      end
      sphke_pkg::KSEL_CUBIC: begin
        sel_f  = p4_cf;
        sel_g  = p4_cg;
        sel_cq = sphke_pkg::CQ_CUBIC;
      end
      sphke_pkg::KSEL_WEND: begin
        sel_f  = 33'((p4_fp >> 16) + 53'(p4_fp[15]));
        sel_g  = 35'((wend_g5 >> 16) + 56'(wend_g5[15]));
        sel_cq = sphke_pkg::CQ_WEND;
      end
      default: ;
    endcase
    // Drop everything outside support or for the unused selector
    if (p4_zero) begin
      sel_f = '0;
      sel_g = '0;
    end
  end

  logic [15:0] p5_dx, p5_dy;
  logic [32:0] p5_f;
  logic [34:0] p5_g;
  logic [31:0] p5_cq;

  always_ff @(posedge clk) begin
    if (adv) begin
      p5_dx <= p4_dx;
      p5_dy <= p4_dy;
      p5_f  <= sel_f;
      p5_g  <= sel_g;
      p5_cq <= sel_cq;
    end
  end

  // Stage 6: scale by the normalization constant
  logic [15:0] p6_dx, p6_dy;
  logic [64:0] p6_nw;
  logic [66:0] p6_mg;

  always_ff @(posedge clk) begin
    if (adv) begin
      p6_dx <= p5_dx;
      p6_dy <= p5_dy;
      p6_nw <= 65'(p5_cq) * 65'(p5_f);
      p6_mg <= 67'(p5_cq) * 67'(p5_g);
    end
  end

  // Stage 7: gradient numerators from the direction magnitudes
  logic [51:0] grad_m;
  logic [15:0] mag_x, mag_y;

  assign grad_m = 52'((p6_mg >> 16) + 67'(p6_mg[15]));
  assign mag_x  = p6_dx[15] ? 16'(~p6_dx + 16'd1) : p6_dx;
  assign mag_y  = p6_dy[15] ? 16'(~p6_dy + 16'd1) : p6_dy;

  logic [NW_W-1:0] p7_nw;
  logic [NW_G-1:0] p7_nx, p7_ny;
  logic            p7_sx, p7_sy;

  always_ff @(posedge clk) begin
    if (adv) begin
      p7_nw <= p6_nw;
      p7_nx <= 68'(grad_m) * 68'(mag_x);
      p7_ny <= 68'(grad_m) * 68'(mag_y);
      p7_sx <= p6_dx[15];
      p7_sy <= p6_dy[15];
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  // ---------------- dividers ----------------
  // Dividing by den << (s-1) leaves the rounding bit as the quotient LSB
  logic [DW_W-1:0] den_w;
  logic [DW_G-1:0] den_g;
  logic [QW-1:0]   qw, qx, qy;
  logic            ow, ox, oy;

  assign den_w = DW_W'(h_sq) << W_SHIFT;
  assign den_g = DW_G'(h_cube) << G_SHIFT;

  sphke_div #(.NUM_W(NW_W), .DEN_W(DW_W)) u_div_w (
    .clk (clk), .en (adv), .num (p7_nw), .den (den_w), .quo (qw), .ovf (ow)
  );

  sphke_div #(.NUM_W(NW_G), .DEN_W(DW_G)) u_div_x (
    .clk (clk), .en (adv), .num (p7_nx), .den (den_g), .quo (qx), .ovf (ox)
  );

  sphke_div #(.NUM_W(NW_G), .DEN_W(DW_G)) u_div_y (
    .clk (clk), .en (adv), .num (p7_ny), .den (den_g), .quo (qy), .ovf (oy)
  );

  // Sideband delay matched to the dividers
  sphke_pkg::side_t sb [0:DIV_LAT];

  assign sb[0] = '{valid: v7, sx: p7_sx, sy: p7_sy};

  for (genvar j = 1; j <= DIV_LAT; j++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) sb[j] <= '0;
      else if (adv) sb[j] <= sb[j-1];
    end
  end

  // ---------------- round, saturate, sign ----------------
  logic        w_big, x_big, y_big;
  logic [31:0] w_rnd, x_rnd, y_rnd;
  logic [31:0] weight_next, grad_x_next, grad_y_next;

  always_comb begin
    w_big = ow || (qw == '1);
    x_big = ox || (qx == '1);
    y_big = oy || (qy == '1);
    w_rnd = 32'((33'(qw) + 33'd1) >> 1);
    x_rnd = 32'((33'(qx) + 33'd1) >> 1);
    y_rnd = 32'((33'(qy) + 33'd1) >> 1);
    weight_next = w_big ? 32'h7FFF_FFFF : w_rnd;
    if (sb[DIV_LAT].sx) grad_x_next = x_big ? 32'h7FFF_FFFF : x_rnd;
    else grad_x_next = x_big ? 32'h8000_0000 : 32'(32'd0 - x_rnd);
    if (sb[DIV_LAT].sy) grad_y_next = y_big ? 32'h7FFF_FFFF : y_rnd;
    else grad_y_next = y_big ? 32'h8000_0000 : 32'(32'd0 - y_rnd);
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= sb[DIV_LAT].valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      weight <= weight_next;
      grad_x <= grad_x_next;
      grad_y <= grad_y_next;
    end
  end

endmodule

@@ src/sphke_checker.sv @@
`timescale 1ns / 1ps

module sphke_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] weight
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(weight))
    else $error("stalled result changed");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // The weight is never negative
  a_weight_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !weight[31])
    else $error("negative weight");

  // Input backpressure only comes from a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

endmodule

bind sph_kernel_evaluator_core sphke_checker u_sphke_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .weight    (weight)
);
